FILE: rtl/core/pfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_pkg: shared types and constants of the face normal unit
// Field widths, internal datapath widths, item structs, controller states
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package pfn_pkg;

    localparam int INDEX_BITS  = 20;
    localparam int COORD_BITS  = 24;
    localparam int NORMAL_BITS = 16;

    // Edge vectors are taken down to at most 31 bits before the cross product
    localparam int DIFF_DROP = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    localparam int DIFF_W    = COORD_BITS + 1 - DIFF_DROP;
    localparam int CROSS_W   = 2 * DIFF_W + 1;
    localparam int MAG_W     = 2 * DIFF_W;
    localparam int WORK_W    = (MAG_W > 31) ? MAG_W : 31;

    // Shared signed multiplier, radicand, root and divider widths
    localparam int MUL_W  = 31;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int REM_W  = 32;
    localparam int NUM_W  = NORMAL_BITS + 30;

    localparam int CNT_W       = 5;
    localparam int MUL_STEPS   = 7;
    localparam int SQ_STEPS    = 4;
    localparam int SQRT_STEPS  = 31;
    localparam int SQRT_START  = 60;

    localparam logic [NORMAL_BITS-1:0] NORM_ONE = NORMAL_BITS'(1) << (NORMAL_BITS - 1);
    localparam logic [NORMAL_BITS-1:0] NORM_MAX = NORM_ONE - NORMAL_BITS'(1);

    typedef struct packed {
        logic [INDEX_BITS-1:0]        vertex_index;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic                         face_is_quad;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]         corner_index;
        logic signed [NORMAL_BITS-1:0] normal_x;
        logic signed [NORMAL_BITS-1:0] normal_y;
        logic signed [NORMAL_BITS-1:0] normal_z;
        logic                          degenerate;
        logic                          last_corner;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ABS,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DLOAD,
        ST_DIV,
        ST_DSTORE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_MUL,
        OP_ABS,
        OP_NORM,
        OP_SQ,
        OP_SQRT,
        OP_DLOAD,
        OP_DIV,
        OP_DSTORE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] step;
        logic [1:0]       comp;
        logic [1:0]       slot;
        logic             quad;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic degen;
        logic norm_done;
    } status_t;

endpackage

FILE: rtl/core/pfn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_datapath: corner store and arithmetic of the face normal unit
// Holds the corners, forms edges, cross product on a shared multiplier,
// normalizes, takes the integer square root and divides bit by bit.
// ----------------------------------------------------------------------------
module pfn_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  pfn_pkg::cmd_t      cmd,
    input  pfn_pkg::in_item_t  in_data,
    output pfn_pkg::status_t   status,
    output pfn_pkg::out_item_t out_data
);
    import pfn_pkg::*;

    logic signed [COORD_BITS-1:0] corner_x_reg [4];
    logic signed [COORD_BITS-1:0] corner_y_reg [4];
    logic signed [COORD_BITS-1:0] corner_z_reg [4];
    logic [INDEX_BITS-1:0]        corner_vertex_reg [4];

    logic signed [DIFF_W-1:0]     u_reg [3];
    logic signed [DIFF_W-1:0]     v_reg [3];
    logic signed [DIFF_W-1:0]     u_next [3];
    logic signed [DIFF_W-1:0]     v_next [3];

    logic signed [MUL_W-1:0]      mul_a;
    logic signed [MUL_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [CROSS_W-1:0]    prod_ext;
    logic signed [CROSS_W-1:0]    cross_reg [3];
    logic [CNT_W-1:0]             acc_step;

    logic [WORK_W-1:0]            mag_reg [3];
    logic [WORK_W-1:0]            mag_next [3];
    logic                         sign_reg [3];
    logic [WORK_W-1:0]            top;
    logic                         top_hi;
    logic                         degen_reg;

    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             rad_reg;
    logic [SUM_W-1:0]             root_reg;
    logic [SUM_W-1:0]             bit_reg;
    logic [SUM_W-1:0]             trial_root;

    logic [ROOT_W-1:0]            len;
    logic [NUM_W-1:0]             num;
    logic [REM_W-1:0]             rem_reg;
    logic [REM_W-1:0]             rem_trial;
    logic [NORMAL_BITS-1:0]       quo_reg;
    logic [NORMAL_BITS-1:0]       q_clamp;
    logic signed [NORMAL_BITS-1:0] comp_val;
    logic signed [NORMAL_BITS-1:0] nrm_reg [3];

    out_item_t                    out_reg;

    // Edge vectors, floor-shifted into DIFF_W bits
    always_comb
    begin
        logic signed [COORD_BITS:0] full_u [3];
        logic signed [COORD_BITS:0] full_v [3];
        if (cmd.quad)
        begin
            full_u[0] = (COORD_BITS+1)'(corner_x_reg[2]) - (COORD_BITS+1)'(corner_x_reg[0]);
            full_u[1] = (COORD_BITS+1)'(corner_y_reg[2]) - (COORD_BITS+1)'(corner_y_reg[0]);
            full_u[2] = (COORD_BITS+1)'(corner_z_reg[2]) - (COORD_BITS+1)'(corner_z_reg[0]);
            full_v[0] = (COORD_BITS+1)'(corner_x_reg[3]) - (COORD_BITS+1)'(corner_x_reg[1]);
            full_v[1] = (COORD_BITS+1)'(corner_y_reg[3]) - (COORD_BITS+1)'(corner_y_reg[1]);
            full_v[2] = (COORD_BITS+1)'(corner_z_reg[3]) - (COORD_BITS+1)'(corner_z_reg[1]);
        end
        else
        begin
            full_u[0] = (COORD_BITS+1)'(corner_x_reg[1]) - (COORD_BITS+1)'(corner_x_reg[0]);
            full_u[1] = (COORD_BITS+1)'(corner_y_reg[1]) - (COORD_BITS+1)'(corner_y_reg[0]);
            full_u[2] = (COORD_BITS+1)'(corner_z_reg[1]) - (COORD_BITS+1)'(corner_z_reg[0]);
            full_v[0] = (COORD_BITS+1)'(corner_x_reg[2]) - (COORD_BITS+1)'(corner_x_reg[0]);
            full_v[1] = (COORD_BITS+1)'(corner_y_reg[2]) - (COORD_BITS+1)'(corner_y_reg[0]);
            full_v[2] = (COORD_BITS+1)'(corner_z_reg[2]) - (COORD_BITS+1)'(corner_z_reg[0]);
        end
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = DIFF_W'(full_u[i] >>> DIFF_DROP);
            v_next[i] = DIFF_W'(full_v[i] >>> DIFF_DROP);
        end
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == OP_MUL)
        begin
            unique case (cmd.step)
                CNT_W'(0): begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[2]); end
                CNT_W'(1): begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[1]); end
                CNT_W'(2): begin mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(v_reg[0]); end
                CNT_W'(3): begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[2]); end
                CNT_W'(4): begin mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(v_reg[1]); end
                CNT_W'(5): begin mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(v_reg[0]); end
                default:   begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (cmd.op == OP_SQ && cmd.step < CNT_W'(3))
        begin
            mul_a = signed'({1'b0, mag_reg[cmd.step[1:0]][MUL_W-2:0]});
            mul_b = mul_a;
        end
    end

    assign prod_ext = CROSS_W'(prod_reg);
    assign acc_step = cmd.step - CNT_W'(1);

    // Magnitudes of the cross product and the largest of them
    always_comb
    begin
        logic signed [CROSS_W-1:0] abs_v;
        for (int i = 0; i < 3; i++)
        begin
            abs_v       = (cross_reg[i] < 0) ? -cross_reg[i] : cross_reg[i];
            mag_next[i] = WORK_W'(abs_v[MAG_W-1:0]);
        end
        top = mag_reg[0];
        if (mag_reg[1] > top)
        begin
            top = mag_reg[1];
        end
        if (mag_reg[2] > top)
        begin
            top = mag_reg[2];
        end
    end

    assign top_hi = |top[WORK_W-1:30];

    // Square root trial, divider trial and output saturation
    assign trial_root = root_reg + bit_reg;
    assign len        = root_reg[ROOT_W-1:0];
    assign num        = (NUM_W'(mag_reg[cmd.comp][29:0]) << (NORMAL_BITS - 1))
                        + NUM_W'(len[ROOT_W-1:1]);
    assign rem_trial  = {rem_reg[REM_W-2:0], quo_reg[NORMAL_BITS-1]};

    always_comb
    begin
        if (sign_reg[cmd.comp])
        begin
            q_clamp  = (quo_reg > NORM_ONE) ? NORM_ONE : quo_reg;
            comp_val = signed'(NORMAL_BITS'(0) - q_clamp);
        end
        else
        begin
            q_clamp  = (quo_reg > NORM_MAX) ? NORM_MAX : quo_reg;
            comp_val = signed'(q_clamp);
        end
    end

    // Hold the degenerate flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg <= 1'b0;
        end
        else if (cmd.op == OP_ABS)
        begin
            degen_reg <= (mag_next[0] == '0) && (mag_next[1] == '0) && (mag_next[2] == '0);
        end
    end

    // Advance the datapath registers as commanded
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.op)
            OP_LOAD:
            begin
                corner_x_reg[cmd.slot]      <= in_data.pos_x;
                corner_y_reg[cmd.slot]      <= in_data.pos_y;
                corner_z_reg[cmd.slot]      <= in_data.pos_z;
                corner_vertex_reg[cmd.slot] <= in_data.vertex_index;
            end
            OP_DIFF:
            begin
                u_reg <= u_next;
                v_reg <= v_next;
            end
            OP_MUL:
            begin
                if (cmd.step != CNT_W'(0))
                begin
                    if (!acc_step[0])
                    begin
                        cross_reg[acc_step[2:1]] <= prod_ext;
                    end
                    else
                    begin
                        cross_reg[acc_step[2:1]] <= cross_reg[acc_step[2:1]] - prod_ext;
                    end
                end
            end
            OP_ABS:
            begin
                mag_reg <= mag_next;
                for (int i = 0; i < 3; i++)
                begin
                    sign_reg[i] <= cross_reg[i] < 0;
                    nrm_reg[i]  <= '0;
                end
            end
            OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (top_hi)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!top[29])
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            OP_SQ:
            begin
                if (cmd.step == CNT_W'(1))
                begin
                    sum_reg <= SUM_W'(prod_reg);
                end
                else if (cmd.step == CNT_W'(2))
                begin
                    sum_reg <= sum_reg + SUM_W'(prod_reg);
                end
                else if (cmd.step == CNT_W'(3))
                begin
                    rad_reg  <= sum_reg + SUM_W'(prod_reg);
                    root_reg <= '0;
                    bit_reg  <= SUM_W'(1) << SQRT_START;
                end
            end
            OP_SQRT:
            begin
                if (rad_reg >= trial_root)
                begin
                    rad_reg  <= rad_reg - trial_root;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DLOAD:
            begin
                rem_reg <= REM_W'(num[NUM_W-1:NORMAL_BITS]);
                quo_reg <= num[NORMAL_BITS-1:0];
            end
            OP_DIV:
            begin
                if (rem_trial >= {1'b0, len})
                begin
                    rem_reg <= rem_trial - {1'b0, len};
                    quo_reg <= {quo_reg[NORMAL_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_trial;
                    quo_reg <= {quo_reg[NORMAL_BITS-2:0], 1'b0};
                end
            end
            OP_DSTORE:
            begin
                nrm_reg[cmd.comp] <= comp_val;
            end
            OP_EMIT:
            begin
                out_reg.corner_index <= corner_vertex_reg[cmd.step[1:0]];
                out_reg.normal_x     <= nrm_reg[0];
                out_reg.normal_y     <= nrm_reg[1];
                out_reg.normal_z     <= nrm_reg[2];
                out_reg.degenerate   <= degen_reg;
                out_reg.last_corner  <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign status.degen     = degen_reg;
    assign status.norm_done = !top_hi && top[29];
    assign out_data         = out_reg;

endmodule

FILE: rtl/core/pfn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfn_ctrl: sequencer of the face normal unit
// Counts corners, steps the datapath through the phases of the normal
// computation and hands results to the output register.
// ----------------------------------------------------------------------------
module pfn_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_quad,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  pfn_pkg::status_t status,
    output pfn_pkg::cmd_t    cmd
);
    import pfn_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       comp_reg, comp_next;
    logic [2:0]       held_reg, held_next;
    logic             quad_reg, quad_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       held_inc;
    logic [1:0]       last_idx;

    assign held_inc = held_reg + 3'd1;
    assign last_idx = quad_reg ? 2'd3 : 2'd2;

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            held_reg      <= '0;
            quad_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            held_reg      <= held_next;
            quad_reg      <= quad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        held_next      = held_reg;
        quad_next      = quad_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = OP_NONE;
        cmd.step       = cnt_reg;
        cmd.comp       = comp_reg;
        cmd.slot       = held_reg[1:0];
        cmd.quad       = quad_reg;
        cmd.last       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (held_inc == 3'd4 || (held_inc == 3'd3 && !in_quad))
                    begin
                        held_next  = '0;
                        quad_next  = held_inc == 3'd4;
                        state_next = ST_DIFF;
                    end
                    else
                    begin
                        held_next = held_inc;
                    end
                end
            end
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op = OP_MUL;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_ABS;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_ABS:
            begin
                cmd.op     = OP_ABS;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cnt_next = '0;
                priority if (status.degen)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.norm_done)
                begin
                    state_next = ST_SQ;
                end
                else
                begin
                    cmd.op = OP_NORM;
                end
            end
            ST_SQ:
            begin
                cmd.op = OP_SQ;
                if (cnt_reg == CNT_W'(SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    comp_next  = '0;
                    state_next = ST_DLOAD;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_DLOAD:
            begin
                cmd.op     = OP_DLOAD;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == CNT_W'(NORMAL_BITS - 1))
                begin
                    state_next = ST_DSTORE;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_DSTORE:
            begin
                cmd.op   = OP_DSTORE;
                cnt_next = '0;
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_DLOAD;
                end
            end
            ST_EMIT:
            begin
                cmd.last = cnt_reg[1:0] == last_idx;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/polygon_face_normal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_face_normal_unit: unit face normal of a triangle or quad
// Top level joining the sequencer, the datapath and the checks.
// ----------------------------------------------------------------------------
// Corners arrive one item per cycle while the unit is collecting. Once a face
// completes, the unit stops accepting and computes the normal on one shared
// multiplier, a bit-serial square root and a bit-serial divider, in order:
// edge setup, cross product, magnitude, normalizing (one-bit shifts until
// the range is reached), squared length, square root and division, then
// one result per cycle for each corner as the consumer takes them. A
// degenerate face skips straight from the normalizing phase to the results.
// Results leave through a registered output stage, so the next face can
// start while the last result still waits.
// ----------------------------------------------------------------------------
module polygon_face_normal_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfn_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pfn_pkg::out_item_t out_data
);
    import pfn_pkg::*;

    cmd_t    cmd;
    status_t status;

    pfn_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_quad   (in_data.face_is_quad),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pfn_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .status   (status),
        .out_data (out_data)
    );

`ifndef SYNTH
    // A corner is stored only on an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |-> in_valid && in_ready)
        else $error("corner stored without an accepted item");

    // A degenerate result carries a zero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
        out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
        else $error("degenerate item with nonzero normal");

    // A regular result carries a nonzero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.degenerate |->
        out_data.normal_x != '0 || out_data.normal_y != '0 || out_data.normal_z != '0)
        else $error("zero normal on a regular item");
`endif

endmodule
